// ----- hdl/cbw_pkg.sv -----
// Shared types and constants of the triangle bounding-box coverage walker.
// Used by the stream interface users, the coverage pipeline and the top level.
package cbw_pkg;

    localparam int COORD_W  = 14;
    localparam int PIX_W    = 10;
    localparam int COLOUR_W = 32;
    localparam int DIFF_W   = COORD_W + 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_IDLE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic                opcode;
        logic [COORD_W-1:0]  vert_a_x;
        logic [COORD_W-1:0]  vert_a_y;
        logic [COORD_W-1:0]  vert_b_x;
        logic [COORD_W-1:0]  vert_b_y;
        logic [COORD_W-1:0]  vert_c_x;
        logic [COORD_W-1:0]  vert_c_y;
        logic [COLOUR_W-1:0] fill_colour;
    } in_word_t;

    typedef struct packed {
        kind_t               kind;
        logic [PIX_W-1:0]    pix_x;
        logic [PIX_W-1:0]    pix_y;
        logic                covered;
        logic [COLOUR_W-1:0] pix_colour;
        logic                last;
    } out_word_t;

    typedef struct packed {
        out_word_t                 base;
        logic                      test;
        logic signed [DIFF_W-1:0]  bc_y;
        logic signed [DIFF_W-1:0]  cb_x;
        logic signed [DIFF_W-1:0]  ca_y;
        logic signed [DIFF_W-1:0]  ac_x;
        logic signed [DIFF_W-1:0]  ac_y;
        logic signed [DIFF_W-1:0]  pc_x;
        logic signed [DIFF_W-1:0]  pc_y;
    } eval_word_t;

endpackage

// ----- hdl/cbw_stream_if.sv -----
// Valid/ready stream channel carrying one word of a chosen payload type.
// Payload types come from cbw_pkg.
interface cbw_stream_if #(parameter type word_t = logic);

    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- hdl/cbw_edge_eval.sv -----
// Three-stage coverage pipeline: edge differences in, result word out.
// Depends on cbw_pkg and cbw_stream_if.
module cbw_edge_eval (
    input  logic        clk,
    input  logic        rst_n,
    cbw_stream_if.sink   eval,
    cbw_stream_if.source result
);
    import cbw_pkg::*;

    localparam int PROD_W = 2 * DIFF_W;
    localparam int EDGE_W = PROD_W + 3;

    typedef struct packed {
        out_word_t                base;
        logic                     test;
        logic signed [PROD_W-1:0] det_a;
        logic signed [PROD_W-1:0] det_b;
        logic signed [PROD_W-1:0] e1_a;
        logic signed [PROD_W-1:0] e1_b;
        logic signed [PROD_W-1:0] e2_a;
        logic signed [PROD_W-1:0] e2_b;
    } prod_word_t;

    eval_word_t s1_reg;
    logic       s1_valid_reg;
    prod_word_t s2_reg;
    prod_word_t s2_next;
    logic       s2_valid_reg;
    out_word_t  s3_reg;
    out_word_t  s3_next;
    logic       s3_valid_reg;

    logic adv1;
    logic adv2;
    logic adv3;

    logic signed [EDGE_W-1:0] det;
    logic signed [EDGE_W-1:0] e1;
    logic signed [EDGE_W-1:0] e2;
    logic signed [EDGE_W-1:0] e3;
    logic                     hit;

    assign adv3 = !s3_valid_reg || result.ready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign eval.ready     = adv1;
    assign result.valid   = s3_valid_reg;
    assign result.payload = s3_reg;

    always_comb
    begin
        s2_next.base  = s1_reg.base;
        s2_next.test  = s1_reg.test;
        s2_next.det_a = PROD_W'($signed(s1_reg.bc_y)) * PROD_W'($signed(s1_reg.ac_x));
        s2_next.det_b = PROD_W'($signed(s1_reg.cb_x)) * PROD_W'($signed(s1_reg.ac_y));
        s2_next.e1_a  = PROD_W'($signed(s1_reg.bc_y)) * PROD_W'($signed(s1_reg.pc_x));
        s2_next.e1_b  = PROD_W'($signed(s1_reg.cb_x)) * PROD_W'($signed(s1_reg.pc_y));
        s2_next.e2_a  = PROD_W'($signed(s1_reg.ca_y)) * PROD_W'($signed(s1_reg.pc_x));
        s2_next.e2_b  = PROD_W'($signed(s1_reg.ac_x)) * PROD_W'($signed(s1_reg.pc_y));
    end

    always_comb
    begin
        det = EDGE_W'($signed(s2_reg.det_a)) + EDGE_W'($signed(s2_reg.det_b));
        e1  = EDGE_W'($signed(s2_reg.e1_a)) + EDGE_W'($signed(s2_reg.e1_b));
        e2  = EDGE_W'($signed(s2_reg.e2_a)) + EDGE_W'($signed(s2_reg.e2_b));
        e3  = det - e1 - e2;
        if (det == '0)
            hit = 1'b0;
        else if (det > 0)
            hit = (e1 >= 0) && (e2 >= 0) && (e3 >= 0);
        else
            hit = (e1 <= 0) && (e2 <= 0) && (e3 <= 0);
        s3_next         = s2_reg.base;
        s3_next.covered = s2_reg.test && hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= eval.valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
            s1_reg <= eval.payload;
        if (adv2)
            s2_reg <= s2_next;
        if (adv3)
            s3_reg <= s3_next;
    end

endmodule

// ----- hdl/triangle_bbox_coverage_walker.sv -----
// Top level of the triangle bounding-box coverage walker.
// Depends on cbw_pkg, cbw_stream_if and cbw_edge_eval.
//
// A load word stores three vertices (unsigned 10.FRAC_BITS, saturated just
// below SCREEN_SIZE) and a colour and restarts the walk at the corner of the
// integer bounding box; until the walk ends each step word returns the next
// pixel of the box, x outer and y inner, with its coverage, colour and a last
// flag. Every word gives exactly one result word. One word is taken per clock
// while ready is high; each result passes the three-register coverage
// pipeline (edge differences, edge products, edge sums and sign test). The
// walk state is updated when a word is accepted, so steps may follow a load
// in consecutive cycles. Ready drops only when all three pipeline registers
// are full and the result is not being taken.
module triangle_bbox_coverage_walker #(
    parameter int SCREEN_SIZE = 1024,
    parameter int FRAC_BITS   = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    cbw_stream_if.sink   item,
    cbw_stream_if.source result
);
    import cbw_pkg::*;

    localparam int          WALK_W  = COORD_W - FRAC_BITS;
    localparam longint      SAT_LIM = (longint'(SCREEN_SIZE) << FRAC_BITS) - 1;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
        if (longint'(v) > SAT_LIM)
            return COORD_W'(SAT_LIM);
        else
            return v;
    endfunction

    function automatic logic [COORD_W-1:0] min3(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b,
                                                input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [COORD_W-1:0] max3(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b,
                                                input logic [COORD_W-1:0] c);
        logic [COORD_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    cbw_stream_if #(.word_t(eval_word_t)) eval_ch ();

    logic [COORD_W-1:0]  vert_reg [6];
    logic [COORD_W-1:0]  vert_next [6];
    logic [COLOUR_W-1:0] colour_reg;
    logic [COLOUR_W-1:0] colour_next;
    logic [WALK_W-1:0]   walk_x_reg;
    logic [WALK_W-1:0]   walk_x_next;
    logic [WALK_W-1:0]   walk_y_reg;
    logic [WALK_W-1:0]   walk_y_next;
    logic [WALK_W-1:0]   box_min_y_reg;
    logic [WALK_W-1:0]   box_min_y_next;
    logic [WALK_W-1:0]   box_max_x_reg;
    logic [WALK_W-1:0]   box_max_x_next;
    logic [WALK_W-1:0]   box_max_y_reg;
    logic [WALK_W-1:0]   box_max_y_next;
    logic                pending_reg;
    logic                pending_next;

    logic [COORD_W-1:0]  sat [6];
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic                accept;
    logic                is_last;
    in_word_t            word;
    eval_word_t          ev;

    assign word         = item.payload;
    assign accept       = item.valid && item.ready;
    assign item.ready   = eval_ch.ready;
    assign eval_ch.valid   = item.valid;
    assign eval_ch.payload = ev;

    assign sat[0] = sat_coord(word.vert_a_x);
    assign sat[1] = sat_coord(word.vert_a_y);
    assign sat[2] = sat_coord(word.vert_b_x);
    assign sat[3] = sat_coord(word.vert_b_y);
    assign sat[4] = sat_coord(word.vert_c_x);
    assign sat[5] = sat_coord(word.vert_c_y);

    assign px      = COORD_W'(walk_x_reg) << FRAC_BITS;
    assign py      = COORD_W'(walk_y_reg) << FRAC_BITS;
    assign is_last = (walk_x_reg == box_max_x_reg) && (walk_y_reg == box_max_y_reg);

    always_comb
    begin
        ev.base.kind       = KIND_PIXEL;
        ev.base.pix_x      = PIX_W'(walk_x_reg);
        ev.base.pix_y      = PIX_W'(walk_y_reg);
        ev.base.covered    = 1'b0;
        ev.base.pix_colour = colour_reg;
        ev.base.last       = is_last;
        ev.test            = 1'b1;
        ev.bc_y = diff(vert_reg[3], vert_reg[5]);
        ev.cb_x = diff(vert_reg[4], vert_reg[2]);
        ev.ca_y = diff(vert_reg[5], vert_reg[1]);
        ev.ac_x = diff(vert_reg[0], vert_reg[4]);
        ev.ac_y = diff(vert_reg[1], vert_reg[5]);
        ev.pc_x = diff(px, vert_reg[4]);
        ev.pc_y = diff(py, vert_reg[5]);
        if (word.opcode == OP_LOAD || !pending_reg)
        begin
            ev.base.kind       = (word.opcode == OP_LOAD) ? KIND_LOAD : KIND_IDLE;
            ev.base.pix_x      = '0;
            ev.base.pix_y      = '0;
            ev.base.pix_colour = '0;
            ev.base.last       = 1'b0;
            ev.test            = 1'b0;
        end
    end

    always_comb
    begin
        vert_next      = vert_reg;
        colour_next    = colour_reg;
        walk_x_next    = walk_x_reg;
        walk_y_next    = walk_y_reg;
        box_min_y_next = box_min_y_reg;
        box_max_x_next = box_max_x_reg;
        box_max_y_next = box_max_y_reg;
        pending_next   = pending_reg;
        if (accept)
        begin
            if (word.opcode == OP_LOAD)
            begin
                vert_next      = sat;
                colour_next    = word.fill_colour;
                walk_x_next    = WALK_W'(min3(sat[0], sat[2], sat[4]) >> FRAC_BITS);
                box_min_y_next = WALK_W'(min3(sat[1], sat[3], sat[5]) >> FRAC_BITS);
                box_max_x_next = WALK_W'(max3(sat[0], sat[2], sat[4]) >> FRAC_BITS);
                box_max_y_next = WALK_W'(max3(sat[1], sat[3], sat[5]) >> FRAC_BITS);
                walk_y_next    = box_min_y_next;
                pending_next   = 1'b1;
            end
            else if (pending_reg)
            begin
                if (is_last)
                    pending_next = 1'b0;
                else if (walk_y_reg < box_max_y_reg)
                    walk_y_next = walk_y_reg + WALK_W'(1);
                else
                begin
                    walk_y_next = box_min_y_reg;
                    walk_x_next = walk_x_reg + WALK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                vert_reg[i] <= '0;
            colour_reg    <= '0;
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            box_min_y_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            vert_reg      <= vert_next;
            colour_reg    <= colour_next;
            walk_x_reg    <= walk_x_next;
            walk_y_reg    <= walk_y_next;
            box_min_y_reg <= box_min_y_next;
            box_max_x_reg <= box_max_x_next;
            box_max_y_reg <= box_max_y_next;
            pending_reg   <= pending_next;
        end
    end

    cbw_edge_eval u_edge_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .eval   (eval_ch.sink),
        .result (result)
    );

endmodule
